// ===== rtl/sdcd_pkg.sv =====
// sdcd_pkg: shared constants and types for the spi dac command decoder
// no dependencies; imported by sdcd_fsm, spi_dac_command_decoder and the bench
package sdcd_pkg;

	// bus command bytes
	localparam logic [7:0] CMD_CH_A    = 8'h31;
	localparam logic [7:0] CMD_CH_B    = 8'h38;
	localparam logic [7:0] CMD_TWO_DEV = 8'h80;

	// field widths
	localparam int BYTE_W  = 8;
	localparam int CHAN_W  = 2;
	localparam int VALUE_W = 16;
	localparam int OUT_W   = 24;

	// one decoded dac write, handed from the fsm to the output register
	typedef struct packed {
		logic               valid;
		logic [CHAN_W-1:0]  channel;
		logic [VALUE_W-1:0] value;
	} sdcd_result_t;

endpackage

// ===== rtl/sdcd_fsm.sv =====
// sdcd_fsm: command decode state machine, one bus byte per enable
// depends on sdcd_pkg for command codes and the result struct
module sdcd_fsm (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic [sdcd_pkg::BYTE_W-1:0]    bus_byte,
	output sdcd_pkg::sdcd_result_t         result
);
	import sdcd_pkg::*;

	// phase codes
	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_C0_HI  = 4'd1;
	localparam logic [3:0] PH_C0_LO  = 4'd2;
	localparam logic [3:0] PH_C1_HI  = 4'd3;
	localparam logic [3:0] PH_C1_LO  = 4'd4;
	localparam logic [3:0] PH_C2_HI  = 4'd5;
	localparam logic [3:0] PH_C2_LO  = 4'd6;
	localparam logic [3:0] PH_C3_HI  = 4'd7;
	localparam logic [3:0] PH_C3_LO  = 4'd8;
	localparam logic [3:0] PH_SECOND = 4'd9;
	localparam logic [3:0] PH_ARG1   = 4'd10;
	localparam logic [3:0] PH_ARG2   = 4'd11;

	localparam logic [CHAN_W-1:0] CH_0 = 2'd0;
	localparam logic [CHAN_W-1:0] CH_1 = 2'd1;
	localparam logic [CHAN_W-1:0] CH_2 = 2'd2;
	localparam logic [CHAN_W-1:0] CH_3 = 2'd3;

	logic [3:0]        phase_q;
	logic [3:0]        phase_d;
	logic [BYTE_W-1:0] high_byte_q;
	logic              two_dev_q;
	logic              two_dev_d;
	logic              take_high;
	logic              emit;
	logic [CHAN_W-1:0] chan;

	// next phase and result decode
	always_comb begin
		phase_d   = phase_q;
		two_dev_d = two_dev_q;
		take_high = 1'b0;
		emit      = 1'b0;
		chan      = CH_0;
		unique case (phase_q)
			PH_SECOND: begin
				priority if (bus_byte == CMD_CH_A) begin
					phase_d = PH_C2_HI;
				end else if (bus_byte == CMD_CH_B) begin
					phase_d = PH_C3_HI;
				end else if (bus_byte == CMD_TWO_DEV) begin
					two_dev_d = 1'b1;
					phase_d   = PH_ARG1;
				end else begin
					// unknown byte ignored, keep waiting
					phase_d = PH_SECOND;
				end
			end
			PH_C0_HI, PH_C1_HI, PH_C2_HI, PH_C3_HI: begin
				take_high = 1'b1;
				phase_d   = phase_q + 4'd1;
			end
			PH_C0_LO, PH_C1_LO: begin
				emit    = 1'b1;
				chan    = (phase_q == PH_C0_LO) ? CH_0 : CH_1;
				phase_d = two_dev_q ? PH_SECOND : PH_IDLE;
			end
			PH_C2_LO, PH_C3_LO: begin
				emit    = 1'b1;
				chan    = (phase_q == PH_C2_LO) ? CH_2 : CH_3;
				phase_d = PH_IDLE;
			end
			PH_ARG1: begin
				phase_d = PH_ARG2;
			end
			PH_ARG2: begin
				phase_d = PH_IDLE;
			end
			default: begin
				// idle, and unreachable codes acting as idle
				priority if (bus_byte == CMD_CH_A) begin
					phase_d = PH_C0_HI;
				end else if (bus_byte == CMD_CH_B) begin
					phase_d = PH_C1_HI;
				end else if (bus_byte == CMD_TWO_DEV) begin
					two_dev_d = 1'b1;
					phase_d   = PH_ARG1;
				end else begin
					// unknown byte ignored
					phase_d = PH_IDLE;
				end
			end
		endcase
	end

	// result toward the output register
	always_comb begin
		result.valid   = en & emit;
		result.channel = chan;
		result.value   = {high_byte_q, bus_byte};
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			high_byte_q <= '0;
			two_dev_q   <= 1'b0;
		end else if (en) begin
			phase_q   <= phase_d;
			two_dev_q <= two_dev_d;
			if (take_high) begin
				high_byte_q <= bus_byte;
			end
		end
	end

endmodule

// ===== rtl/spi_dac_command_decoder.sv =====
// spi_dac_command_decoder: top level, input register, decoder and output register
// depends on sdcd_pkg and sdcd_fsm
//
// channel  dir  fields (tdata, lsb first)
// s_axis   in   bus_byte[7:0]
// m_axis   out  dac_channel[1:0], dac_value[17:2], zero pad [23:18]
//
// one byte is taken per cycle while s_axis_tready is high; a byte is held in the input register,
// is decoded combinationally, and any dac write is registered in the output register as the byte moves on.
// arst_n clears the decoder to idle, single device, and empties both registers.
// a stalled result holds the input register; new bytes still enter when it is empty.
module spi_dac_command_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [sdcd_pkg::BYTE_W-1:0]   s_axis_tdata,  // bus_byte[7:0]
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [sdcd_pkg::OUT_W-1:0]    m_axis_tdata   // dac_channel[1:0], dac_value[17:2]
);
	import sdcd_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;
	sdcd_result_t      res;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	// the input word moves on when the output register has room
	assign advance       = valid_s1 & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// decoder
	sdcd_fsm u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.bus_byte (byte_s1),
		.result   (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (~out_valid_q | m_axis_tready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_data_q <= {{(OUT_W-CHAN_W-VALUE_W){1'b0}}, res.value, res.channel};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
	// pad bits of a result word are zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[OUT_W-1:CHAN_W+VALUE_W] == '0))
		else $error("nonzero pad bits in result word");

	// a blocked input word is kept, not dropped
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input word lost while blocked");

	// a result is only decoded from a word that moves on
	a_emit_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> advance)
		else $error("result decoded without advancing input word");

	// a decoded result shows up at the output next cycle
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |=> m_axis_tvalid)
		else $error("decoded result missing from output register");
`endif

endmodule

// ===== bench/spi_dac_command_decoder_tb.sv =====
// spi_dac_command_decoder_tb: self-checking bench for the spi dac command decoder
// drives bus bytes on s_axis, predicts dac writes in a local decoder model, checks m_axis
// depends on sdcd_pkg and spi_dac_command_decoder
`timescale 1ns / 100ps

module spi_dac_command_decoder_tb;

	import sdcd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 10;

	// decoder phases of the local prediction
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CH0_HI,
		ST_CH0_LO,
		ST_CH1_HI,
		ST_CH1_LO,
		ST_CH2_HI,
		ST_CH2_LO,
		ST_CH3_HI,
		ST_CH3_LO,
		ST_WAIT_DEV2,
		ST_SKIP1,
		ST_SKIP2
	} dec_state_t;

	typedef struct {
		logic [CHAN_W-1:0]  channel;
		logic [VALUE_W-1:0] value;
	} dac_write_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [BYTE_W-1:0]    s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OUT_W-1:0]     m_axis_tdata;

	// predicted decoder state
	dec_state_t           dec_state = ST_IDLE;
	logic [7:0]           latched_hi = '0;
	logic                 dual_dev = 1'b0;
	dac_write_t           expected_writes[$];

	// idling controls and counters
	int                   tx_idle_pct = 0;
	int                   rx_idle_pct = 0;
	int                   rx_hold_left = 0;
	int                   cycle_count = 0;
	int                   bytes_sent = 0;
	int                   writes_checked = 0;
	int                   error_count = 0;
	int                   chan_hits[4] = '{0, 0, 0, 0};

	spi_dac_command_decoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// 2 ns clock
	initial begin
		forever #1 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t timeout after %0d cycles, %0d writes still pending",
				$time, cycle_count, expected_writes.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// command byte in idle or while waiting for the second device
	function automatic void take_command(input logic [7:0] b, input dec_state_t hi_a,
			input dec_state_t hi_b);
		if (b == CMD_CH_A) begin
			dec_state = hi_a;
		end else if (b == CMD_CH_B) begin
			dec_state = hi_b;
		end else if (b == CMD_TWO_DEV) begin
			dual_dev = 1'b1;
			dec_state = ST_SKIP1;
		end
	endfunction

	// advance the predicted decoder by one bus byte, queue any dac write
	function automatic void predict_bus_byte(input logic [7:0] b);
		dac_write_t w;
		case (dec_state)
			ST_CH0_HI, ST_CH1_HI, ST_CH2_HI, ST_CH3_HI: begin
				latched_hi = b;
				dec_state = dec_state_t'(dec_state + 4'd1);
			end
			ST_CH0_LO, ST_CH1_LO, ST_CH2_LO, ST_CH3_LO: begin
				case (dec_state)
					ST_CH0_LO: w.channel = 2'd0;
					ST_CH1_LO: w.channel = 2'd1;
					ST_CH2_LO: w.channel = 2'd2;
					default:   w.channel = 2'd3;
				endcase
				w.value = {latched_hi, b};
				expected_writes.push_back(w);
				// second device writes always return to idle
				if (w.channel >= 2'd2 || !dual_dev)
					dec_state = ST_IDLE;
				else
					dec_state = ST_WAIT_DEV2;
			end
			ST_WAIT_DEV2: take_command(b, ST_CH2_HI, ST_CH3_HI);
			ST_SKIP1: dec_state = ST_SKIP2;
			ST_SKIP2: dec_state = ST_IDLE;
			default: begin
				dec_state = ST_IDLE;
				take_command(b, ST_CH0_HI, ST_CH1_HI);
			end
		endcase
	endfunction

	// offer one byte, with random idle cycles ahead of it, and wait for acceptance
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_bus_byte(b);
		bytes_sent = bytes_sent + 1;
	endtask

	task automatic send_write(input logic [7:0] cmd, input logic [15:0] value);
		send_byte(cmd);
		send_byte(value[15:8]);
		send_byte(value[7:0]);
	endtask

	task automatic stop_sending();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (expected_writes.size() != 0)
			@(posedge clk);
	endtask

	// data byte biased toward extremes and command look-alikes
	function automatic logic [7:0] pick_data_byte();
		case ($urandom_range(0, 9))
			0: return CMD_CH_A;
			1: return CMD_CH_B;
			2: return CMD_TWO_DEV;
			3: return 8'h00;
			4: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// receiver: random stalls, long hold-off on request, result check
	always @(posedge clk) begin
		dac_write_t w;
		logic [CHAN_W-1:0]  got_chan;
		logic [VALUE_W-1:0] got_value;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_chan  = m_axis_tdata[CHAN_W-1:0];
			got_value = m_axis_tdata[CHAN_W+VALUE_W-1:CHAN_W];
			if (expected_writes.size() == 0) begin
				$display("%0t unexpected word: expected none, actual channel %0d value %04h",
					$time, got_chan, got_value);
				error_count = error_count + 1;
			end else begin
				w = expected_writes.pop_front();
				if (got_chan !== w.channel) begin
					$display("%0t dac_channel: expected %0d, actual %0d",
						$time, w.channel, got_chan);
					error_count = error_count + 1;
				end
				if (got_value !== w.value) begin
					$display("%0t dac_value: expected %04h, actual %04h",
						$time, w.value, got_value);
					error_count = error_count + 1;
				end
				chan_hits[w.channel] = chan_hits[w.channel] + 1;
			end
			writes_checked = writes_checked + 1;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left = rx_hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// writes to channels 0 and 1 at value extremes, single device
	task automatic test_single_device_writes();
		send_write(CMD_CH_A, 16'h0000);
		send_write(CMD_CH_B, 16'hFFFF);
	endtask

	// unknown bytes in idle are dropped
	task automatic test_ignored_bytes();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_write(CMD_CH_A, 16'h8001);
	endtask

	// mode command skips two arguments even if they look like commands
	task automatic test_two_device_mode();
		send_byte(CMD_TWO_DEV);
		send_byte(CMD_CH_A);
		send_byte(CMD_CH_B);
		send_write(CMD_CH_A, 16'hA55A);
		// unknown byte while waiting for the second device command
		send_byte(8'h7F);
		send_write(CMD_CH_B, 16'h1234);
	endtask

	// second device on channel 2, return to idle, mode command in the second wait
	task automatic test_second_device_commands();
		send_write(CMD_CH_B, 16'h8031);
		send_write(CMD_CH_A, 16'h0102);
		send_write(CMD_CH_A, 16'h3880);
		send_byte(CMD_TWO_DEV);
		send_byte(8'h31);
		send_byte(8'h80);
		send_write(CMD_CH_B, 16'hFF00);
	endtask

	// mostly well-formed command sequences with random content, some noise
	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_bytes);
		int start;
		int pick;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				send_write($urandom_range(0, 1) ? CMD_CH_B : CMD_CH_A,
					{pick_data_byte(), pick_data_byte()});
			end else if (pick < 75) begin
				send_byte(CMD_TWO_DEV);
				send_byte(pick_data_byte());
				send_byte(pick_data_byte());
			end else if (pick < 80) begin
				// broken sequence: command then a single byte
				send_byte($urandom_range(0, 1) ? CMD_CH_B : CMD_CH_A);
				send_byte(pick_data_byte());
			end else if (pick < 98) begin
				send_byte(8'($urandom_range(0, 255)));
			end else begin
				// sender goes quiet until all writes are out
				stop_sending();
				wait_drained();
			end
		end
	endtask

	// receiver holds off a long stretch so the decoder fills and stalls its input
	task automatic test_output_backpressure();
		int k;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_left = 400;
		for (k = 0; k < 20; k++)
			send_write($urandom_range(0, 1) ? CMD_CH_B : CMD_CH_A,
				16'($urandom_range(0, 65535)));
		stop_sending();
		wait_drained();
	endtask

	initial begin
		int k;
		for (k = 0; k < 12; k++)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 13;
		rx_idle_pct = 79;
		test_single_device_writes();
		test_ignored_bytes();
		test_two_device_mode();
		test_second_device_commands();

		test_random_traffic(13, 79, 235);
		test_random_traffic(79, 13, 235);
		test_random_traffic(0, 0, 235);
		test_output_backpressure();

		stop_sending();
		wait_drained();
		for (k = 0; k < DRAIN_CYCLES; k++)
			@(posedge clk);

		$display("covered %0d bus bytes and %0d dac writes (ch0 %0d, ch1 %0d, ch2 %0d, ch3 %0d)",
			bytes_sent, writes_checked, chan_hits[0], chan_hits[1], chan_hits[2],
			chan_hits[3]);
		$display("with sender and receiver stalls, a long output hold-off and drain pauses");
		if (error_count == 0 && expected_writes.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0t %0d mismatches, %0d writes never arrived",
				$time, error_count, expected_writes.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== spi_dac_command_decoder.f =====
rtl/sdcd_pkg.sv
rtl/sdcd_fsm.sv
rtl/spi_dac_command_decoder.sv
bench/spi_dac_command_decoder_tb.sv
